[hdl/aes_blk_pkg.sv]
package aes_blk_pkg;

	localparam int unsigned RoundsMax = 14;
	localparam int unsigned KeysMax = RoundsMax + 1;

	// Configuration register indexes
	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_0 = 3'd1;
	localparam logic [2:0] REG_KEY_1 = 3'd2;
	localparam logic [2:0] REG_KEY_2 = 3'd3;
	localparam logic [2:0] REG_KEY_3 = 3'd4;

	// Key size codes
	localparam logic [1:0] KSZ_128 = 2'd0;
	localparam logic [1:0] KSZ_192 = 2'd1;
	localparam logic [1:0] KSZ_256 = 2'd2;

	typedef logic [KeysMax-1:0][127:0] rk_array_t;

	typedef struct packed {
		logic en;
		logic final_rnd;
		logic bypass;
	} rnd_ctl_t;

	// S-box, entry 0 in the top byte
	localparam logic [2047:0] SBOX_TABLE = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(input logic [7:0] v);
		sbox = SBOX_TABLE[2047 - 8*v -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// multiply by 2 in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

[hdl/aes_block_encrypt.sv]
// Channel   | Signals                    | Content (lowest bits first)
// ----------+----------------------------+--------------------------------------
// input     | s_tvalid s_tready s_tdata  | plain_upper[63:0], plain_lower[127:64]
// output    | m_tvalid m_tready m_tdata  | cipher_upper[63:0], cipher_lower[127:64]
// config    | wr_en wr_index wr_data     | 0 key_size, 1..4 key_bits_0..3
//
// One request enters per cycle while s_tready is high; initial key add plus 14
// round stages form the pipe; tail stages unused by 128/192-bit keys pass data.
// After reset and after each config write the key expander builds one 32-bit
// schedule word per cycle, 44, 52 or 60 words in all, s_tready low meanwhile.
// A stall on m_tready freezes the whole pipe; nothing is dropped or repeated.
module aes_block_encrypt
	import aes_blk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // plain_upper, plain_lower
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // cipher_upper, cipher_lower
	input  logic         wr_en,
	input  logic [2:0]   wr_index,
	input  logic [63:0]  wr_data
);

	rk_array_t    rkeys;
	logic [3:0]   num_rounds;
	logic         keys_ready;
	logic         pipe_en;
	logic         valid_s0;
	logic [127:0] data_s0;
	logic         vld [RoundsMax+1];
	logic [127:0] dat [RoundsMax+1];

	aes_blk_kexp u_kexp (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.rkeys      (rkeys),
		.num_rounds (num_rounds),
		.ready      (keys_ready)
	);

	// whole pipe advances unless the output is held
	assign pipe_en  = !vld[RoundsMax] || m_tready;
	assign s_tready = pipe_en && keys_ready;

	// initial AddRoundKey; byte 0 in the top bits of the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (pipe_en) begin
			valid_s0 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			data_s0 <= {s_tdata[63:0], s_tdata[127:64]} ^ rkeys[0];
		end
	end

	assign vld[0] = valid_s0;
	assign dat[0] = data_s0;

	for (genvar r = 1; r <= RoundsMax; r++) begin : g_round
		rnd_ctl_t ctl;
		assign ctl.en        = pipe_en;
		assign ctl.final_rnd = (num_rounds == 4'(r));
		assign ctl.bypass    = (num_rounds < 4'(r));

		aes_blk_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.in_valid  (vld[r-1]),
			.in_data   (dat[r-1]),
			.rkey      (rkeys[r]),
			.out_valid (vld[r]),
			.out_data  (dat[r])
		);
	end

	assign m_tvalid = vld[RoundsMax];
	assign m_tdata  = {dat[RoundsMax][63:0], dat[RoundsMax][127:64]};

endmodule

[hdl/aes_blk_kexp.sv]
module aes_blk_kexp
	import aes_blk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	output rk_array_t   rkeys,
	output logic [3:0]  num_rounds,
	output logic        ready
);

	logic [1:0]  key_size_q;
	logic [63:0] key_q [4];
	logic        busy_q;
	logic [5:0]  idx_q;
	logic [2:0]  mod_q;
	logic [7:0]  rcon_q;
	logic [31:0] win_q [8];
	rk_array_t   rk_q;

	logic [3:0]  nk;
	logic [2:0]  back_sel;
	logic [5:0]  last_idx;
	logic [31:0] key_word, t_word, new_word;
	logic        wr_hit;

	always_comb begin
		case (key_size_q)
			KSZ_128: begin
				nk = 4'd4;
				back_sel = 3'd4;
				last_idx = 6'd43;
			end
			KSZ_192: begin
				nk = 4'd6;
				back_sel = 3'd2;
				last_idx = 6'd51;
			end
			default: begin
				nk = 4'd8;
				back_sel = 3'd0;
				last_idx = 6'd59;
			end
		endcase
	end

	assign key_word = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];

	always_comb begin
		if (mod_q == 3'd0)
			t_word = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
		else if (nk == 4'd8 && mod_q == 3'd4)
			t_word = sub_word(win_q[7]);
		else
			t_word = win_q[7];
		new_word = ({2'b00, idx_q} < {4'b0000, nk}) ? key_word : (win_q[back_sel] ^ t_word);
	end

	assign wr_hit = wr_en && (wr_index <= REG_KEY_3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= KSZ_128;
			for (int k = 0; k < 4; k++) key_q[k] <= '0;
			busy_q <= 1'b1;
			idx_q  <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (wr_hit) begin
			case (wr_index)
				REG_KEY_SIZE: key_size_q <= wr_data[1:0];
				REG_KEY_0:    key_q[0] <= wr_data;
				REG_KEY_1:    key_q[1] <= wr_data;
				REG_KEY_2:    key_q[2] <= wr_data;
				REG_KEY_3:    key_q[3] <= wr_data;
				default:      ;
			endcase
			busy_q <= 1'b1;
			idx_q  <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			idx_q <= idx_q + 6'd1;
			mod_q <= ({1'b0, mod_q} == nk - 4'd1) ? 3'd0 : mod_q + 3'd1;
			if (mod_q == 3'd0 && {2'b00, idx_q} >= {4'b0000, nk}) rcon_q <= xtime(rcon_q);
			if (idx_q == last_idx) busy_q <= 1'b0;
		end
	end

	// word window and round key store, payload only
	always_ff @(posedge clk) begin
		if (busy_q && !wr_hit) begin
			for (int k = 0; k < 7; k++) win_q[k] <= win_q[k+1];
			win_q[7] <= new_word;
			rk_q[idx_q[5:2]][127 - 32*idx_q[1:0] -: 32] <= new_word;
		end
	end

	assign rkeys = rk_q;
	assign num_rounds = nk + 4'd6;
	assign ready = !busy_q;

endmodule

[hdl/aes_blk_round.sv]
module aes_blk_round
	import aes_blk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rnd_ctl_t     ctl,
	input  logic         in_valid,
	input  logic [127:0] in_data,
	input  logic [127:0] rkey,
	output logic         out_valid,
	output logic [127:0] out_data
);

	logic [7:0]   b [16];
	logic [7:0]   t [16];
	logic [7:0]   mc [16];
	logic [127:0] nxt;
	logic         valid_s1;
	logic [127:0] data_s1;

	always_comb begin
		for (int n = 0; n < 16; n++) b[n] = in_data[127 - 8*n -: 8];
		// SubBytes + ShiftRows
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r + 4*c] = sbox(b[r + 4*((c + r) % 4)]);
		// MixColumns
		for (int c = 0; c < 4; c++) begin
			mc[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			mc[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
			mc[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
			mc[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
		end
		for (int n = 0; n < 16; n++)
			nxt[127 - 8*n -: 8] = (ctl.final_rnd ? t[n] : mc[n]) ^ rkey[127 - 8*n -: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			data_s1 <= ctl.bypass ? in_data : nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = data_s1;

endmodule
